// ----- rtl/rhbh_pkg.sv -----
// Shared types and constants for the RGB histogram bar-height engine.
// Used by rhbh_divider and rgb_histogram_bar_heights; depends on nothing.
`default_nettype none

package rhbh_pkg;

  // Histogram geometry.
  localparam int unsigned NUM_BINS = 256;
  localparam int unsigned COUNT_W  = 32;
  localparam int unsigned BIN_W    = $clog2(NUM_BINS);
  localparam int unsigned NUM_CH   = 3;

  // Field widths of the command and result beats.
  localparam int unsigned OPC_W      = 2;
  localparam int unsigned SAMPLE_W   = 8;
  localparam int unsigned COL_W      = 12;
  localparam int unsigned DIM_W      = 13;
  localparam int unsigned MASK_W     = 3;
  localparam int unsigned PEAK_OUT_W = 32;

  // Scaling arithmetic: quotient of (2*h*c + p) / (2*p).
  localparam int unsigned PROD_W = DIM_W + COUNT_W;
  localparam int unsigned NUM_W  = PROD_W + 2;
  localparam int unsigned DEN_W  = COUNT_W + 1;

  // Configuration port.
  localparam int unsigned APB_AW = 4;
  localparam int unsigned APB_DW = 32;

  // Register reset values.
  localparam logic [MASK_W-1:0] MASK_RST   = 3'd7;
  localparam logic [DIM_W-1:0]  WIDTH_RST  = 13'd256;
  localparam logic [DIM_W-1:0]  HEIGHT_RST = 13'd200;

  // Command opcodes; the fourth code is ignored.
  typedef enum logic [OPC_W-1:0] {
    OP_CLEAR = 2'd0,
    OP_ADD   = 2'd1,
    OP_QUERY = 2'd2
  } opcode_e;

  // Register indexes on the configuration port.
  typedef enum logic [1:0] {
    REG_CHANNEL_MASK = 2'd0,
    REG_OUT_WIDTH    = 2'd1,
    REG_OUT_HEIGHT   = 2'd2
  } reg_idx_e;

  typedef struct packed {
    logic [OPC_W-1:0]    opcode;
    logic [SAMPLE_W-1:0] red_sample;
    logic [SAMPLE_W-1:0] green_sample;
    logic [SAMPLE_W-1:0] blue_sample;
    logic [COL_W-1:0]    column;
  } cmd_t;

  typedef struct packed {
    logic [DIM_W-1:0]      red_top;
    logic [DIM_W-1:0]      green_top;
    logic [DIM_W-1:0]      blue_top;
    logic [PEAK_OUT_W-1:0] peak_value;
  } result_t;

  // Divider request and response groups.
  typedef struct packed {
    logic             start;
    logic [NUM_W-1:0] dividend;
    logic [DEN_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [NUM_W-1:0] quotient;
  } div_rsp_t;

endpackage

`default_nettype wire

// ----- rtl/rhbh_divider.sv -----
// Bit-serial restoring divider that produces one quotient bit per cycle.
// Depends on rhbh_pkg for its widths and request/response structs.
`default_nettype none

module rhbh_divider (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire rhbh_pkg::div_req_t req_i,
  output rhbh_pkg::div_rsp_t      rsp_o
);

  localparam int unsigned CNT_W = $clog2(rhbh_pkg::NUM_W + 1);

  logic                         busy_q, busy_d;
  logic                         done_q, done_d;
  logic [CNT_W-1:0]             cnt_q, cnt_d;
  logic [rhbh_pkg::DEN_W-1:0]   rem_q, rem_d;
  logic [rhbh_pkg::NUM_W-1:0]   quo_q, quo_d;
  logic [rhbh_pkg::DEN_W-1:0]   den_q;
  logic [rhbh_pkg::DEN_W:0]     trial;
  logic [rhbh_pkg::DEN_W:0]     diff;
  logic                         fits;

  // One restoring step: shift in the next dividend bit and try to subtract.
  assign trial = {rem_q, quo_q[rhbh_pkg::NUM_W-1]};
  assign diff  = trial - {1'b0, den_q};
  assign fits  = (trial >= {1'b0, den_q});

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = CNT_W'(rhbh_pkg::NUM_W);
      rem_d  = '0;
      quo_d  = req_i.dividend;
    end else if (busy_q) begin
      rem_d = fits ? diff[rhbh_pkg::DEN_W-1:0] : trial[rhbh_pkg::DEN_W-1:0];
      quo_d = {quo_q[rhbh_pkg::NUM_W-2:0], fits};
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    if (req_i.start) begin
      den_q <= req_i.divisor;
    end
  end

  assign rsp_o.busy     = busy_q;
  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

endmodule

`default_nettype wire

// ----- rtl/rgb_histogram_bar_heights.sv -----
// Top level of the three-channel 256-bin histogram with bar-height queries.
// Depends on rhbh_pkg and instantiates rhbh_divider.
//
//  Channel   Direction  Handshake                      Beat
//  command   in         start high, busy low           cmd_i (rhbh_pkg::cmd_t)
//  result    out        result_valid_o, one cycle      result_o (rhbh_pkg::result_t)
//  config    in/out     psel, penable, pwrite, pready  paddr, pwdata, prdata
//
// A clear is accepted, then a sweep writes one zero per cycle into every
// channel's bin memory. The same sweep runs after reset, so busy is high
// until it has passed every bin. An add reads the bins on the accepting edge
// and writes them back in the following cycle. A query runs the three
// channels in turn through ST_MUL, ST_START and ST_WAIT on the shared
// bit-serial divider; its beat follows ST_OUT in the next cycle.
// Results cannot be stalled; each is shown for exactly one cycle.
`default_nettype none

module rgb_histogram_bar_heights (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            start,
  output logic                                 busy,
  input  wire rhbh_pkg::cmd_t                  cmd_i,
  output logic                                 result_valid_o,
  output rhbh_pkg::result_t                    result_o,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [rhbh_pkg::APB_AW-1:0]     paddr,
  input  wire logic [rhbh_pkg::APB_DW-1:0]     pwdata,
  output logic [rhbh_pkg::APB_DW-1:0]          prdata,
  output logic                                 pready
);

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_ADD   = 7'b0000010,
    ST_MUL   = 7'b0000100,
    ST_START = 7'b0001000,
    ST_WAIT  = 7'b0010000,
    ST_OUT   = 7'b0100000,
    ST_CLEAR = 7'b1000000
  } state_e;

  state_e                          state_q, state_d;
  logic [1:0]                      ch_q, ch_d;
  logic [rhbh_pkg::BIN_W-1:0]      clr_idx_q, clr_idx_d;
  logic [rhbh_pkg::COUNT_W-1:0]    peak_q, peak_d;
  logic                            res_vld_q;

  logic [rhbh_pkg::MASK_W-1:0]     mask_q;
  logic [rhbh_pkg::DIM_W-1:0]      width_q;
  logic [rhbh_pkg::DIM_W-1:0]      height_q;

  logic                            accept;
  logic                            rd_en;
  logic                            clr_en;
  logic                            sweep;
  logic [1:0]                      reg_idx;
  logic                            cfg_wr;

  logic [rhbh_pkg::SAMPLE_W-1:0]   sample   [rhbh_pkg::NUM_CH];
  logic [rhbh_pkg::BIN_W-1:0]      rd_addr  [rhbh_pkg::NUM_CH];
  logic [rhbh_pkg::BIN_W-1:0]      addr_q   [rhbh_pkg::NUM_CH];
  logic                            add_en_q [rhbh_pkg::NUM_CH];
  logic [rhbh_pkg::COUNT_W-1:0]    rd_q     [rhbh_pkg::NUM_CH];
  logic [rhbh_pkg::COUNT_W-1:0]    eff_cnt  [rhbh_pkg::NUM_CH];
  logic [rhbh_pkg::COUNT_W-1:0]    inc_cnt  [rhbh_pkg::NUM_CH];
  logic                            wr_en    [rhbh_pkg::NUM_CH];
  logic [rhbh_pkg::DIM_W-1:0]      tops_q   [rhbh_pkg::NUM_CH];
  logic                            col_hi_q;

  logic [rhbh_pkg::PROD_W-1:0]     prod_q;
  logic [rhbh_pkg::DIM_W-1:0]      top_calc;
  logic                            bar_empty;
  rhbh_pkg::result_t               result_q;
  rhbh_pkg::div_req_t              div_req;
  rhbh_pkg::div_rsp_t              div_rsp;

  // Command handshake.
  assign busy   = (state_q != ST_IDLE);
  assign accept = start && !busy;
  assign rd_en  = accept && ((cmd_i.opcode == rhbh_pkg::OP_ADD) ||
                             (cmd_i.opcode == rhbh_pkg::OP_QUERY));
  assign clr_en = accept && (cmd_i.opcode == rhbh_pkg::OP_CLEAR);
  assign sweep  = (state_q == ST_CLEAR);

  // Configuration registers on the APB-style port.
  assign pready  = 1'b1;
  assign reg_idx = paddr[rhbh_pkg::APB_AW-1:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q   <= rhbh_pkg::MASK_RST;
      width_q  <= rhbh_pkg::WIDTH_RST;
      height_q <= rhbh_pkg::HEIGHT_RST;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        rhbh_pkg::REG_CHANNEL_MASK: mask_q   <= pwdata[rhbh_pkg::MASK_W-1:0];
        rhbh_pkg::REG_OUT_WIDTH:    width_q  <= pwdata[rhbh_pkg::DIM_W-1:0];
        rhbh_pkg::REG_OUT_HEIGHT:   height_q <= pwdata[rhbh_pkg::DIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      rhbh_pkg::REG_CHANNEL_MASK: prdata = rhbh_pkg::APB_DW'(mask_q);
      rhbh_pkg::REG_OUT_WIDTH:    prdata = rhbh_pkg::APB_DW'(width_q);
      rhbh_pkg::REG_OUT_HEIGHT:   prdata = rhbh_pkg::APB_DW'(height_q);
      default:                    prdata = '0;
    endcase
  end

  // Per-channel read addresses: the sample for an add, the column for a query.
  assign sample[0] = cmd_i.red_sample;
  assign sample[1] = cmd_i.green_sample;
  assign sample[2] = cmd_i.blue_sample;

  for (genvar g = 0; g < rhbh_pkg::NUM_CH; g++) begin : g_chan
    logic [rhbh_pkg::COUNT_W-1:0] bins_q [rhbh_pkg::NUM_BINS];
    logic                         mem_we;
    logic [rhbh_pkg::BIN_W-1:0]   wr_addr;
    logic [rhbh_pkg::COUNT_W-1:0] wr_data;

    assign rd_addr[g] = (cmd_i.opcode == rhbh_pkg::OP_QUERY) ?
                        rhbh_pkg::BIN_W'(cmd_i.column) : rhbh_pkg::BIN_W'(sample[g]);

    // One write port: zeros from the clearing sweep, else the add write-back.
    assign mem_we  = sweep || wr_en[g];
    assign wr_addr = sweep ? clr_idx_q : addr_q[g];
    assign wr_data = sweep ? '0 : inc_cnt[g];

    // Bin memory: registered read on accept, one write per cycle.
    always_ff @(posedge clk_i) begin
      if (rd_en) begin
        rd_q[g] <= bins_q[rd_addr[g]];
      end
      if (mem_we) begin
        bins_q[wr_addr] <= wr_data;
      end
    end

    // Per-item add controls, latched with the read.
    always_ff @(posedge clk_i) begin
      if (rd_en) begin
        addr_q[g]   <= rd_addr[g];
        add_en_q[g] <= mask_q[g] &&
                       (32'(sample[g]) < 32'(rhbh_pkg::NUM_BINS));
      end
    end

    // Saturating increment of the stored count.
    assign eff_cnt[g] = rd_q[g];
    assign inc_cnt[g] = (&eff_cnt[g]) ? eff_cnt[g] :
                        eff_cnt[g] + rhbh_pkg::COUNT_W'(1);
    assign wr_en[g]   = (state_q == ST_ADD) && add_en_q[g];
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      col_hi_q <= (32'(cmd_i.column) >= 32'(rhbh_pkg::NUM_BINS));
    end
  end

  // Running peak over the bins that lie below the output width.
  always_comb begin
    peak_d = peak_q;
    if (clr_en) begin
      peak_d = '0;
    end else begin
      for (int c = 0; c < rhbh_pkg::NUM_CH; c++) begin
        if (wr_en[c] && (32'(addr_q[c]) < 32'(width_q)) && (inc_cnt[c] > peak_d)) begin
          peak_d = inc_cnt[c];
        end
      end
    end
  end

  // Bar top for the channel in work, taken from the divider quotient.
  assign bar_empty = !mask_q[ch_q] || (peak_q == '0) || col_hi_q;
  always_comb begin
    if (bar_empty) begin
      top_calc = height_q;
    end else if (div_rsp.quotient >= rhbh_pkg::NUM_W'(height_q)) begin
      top_calc = '0;
    end else begin
      top_calc = height_q - div_rsp.quotient[rhbh_pkg::DIM_W-1:0];
    end
  end

  // Divider request: (2*h*c + p) / (2*p).
  assign div_req.start    = (state_q == ST_START);
  assign div_req.dividend = rhbh_pkg::NUM_W'({prod_q, 1'b0}) + rhbh_pkg::NUM_W'(peak_q);
  assign div_req.divisor  = {peak_q, 1'b0};

  rhbh_divider u_divider (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // Sequencer: clearing sweep, add write-back, or per channel multiply,
  // divide and store, then the result beat.
  always_comb begin
    state_d   = state_q;
    ch_d      = ch_q;
    clr_idx_d = clr_idx_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept && (cmd_i.opcode == rhbh_pkg::OP_ADD)) begin
          state_d = ST_ADD;
        end else if (accept && (cmd_i.opcode == rhbh_pkg::OP_QUERY)) begin
          state_d = ST_MUL;
          ch_d    = '0;
        end else if (clr_en) begin
          state_d   = ST_CLEAR;
          clr_idx_d = '0;
        end
      end
      ST_CLEAR: begin
        clr_idx_d = clr_idx_q + rhbh_pkg::BIN_W'(1);
        if (clr_idx_q == rhbh_pkg::BIN_W'(rhbh_pkg::NUM_BINS - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_ADD:   state_d = ST_IDLE;
      ST_MUL:   state_d = ST_START;
      ST_START: state_d = ST_WAIT;
      ST_WAIT: begin
        if (div_rsp.done) begin
          if (ch_q == 2'(rhbh_pkg::NUM_CH - 1)) begin
            state_d = ST_OUT;
          end else begin
            ch_d    = ch_q + 2'd1;
            state_d = ST_MUL;
          end
        end
      end
      ST_OUT:   state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // Reset starts a clearing sweep of all bins.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      ch_q      <= '0;
      clr_idx_q <= '0;
      peak_q    <= '0;
      res_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      ch_q      <= ch_d;
      clr_idx_q <= clr_idx_d;
      peak_q    <= peak_d;
      res_vld_q <= (state_q == ST_OUT);
    end
  end

  // Query datapath: product, per-channel tops and the result beat.
  always_ff @(posedge clk_i) begin
    if (state_q == ST_MUL) begin
      prod_q <= rhbh_pkg::PROD_W'(height_q) * rhbh_pkg::PROD_W'(eff_cnt[ch_q]);
    end
    if ((state_q == ST_WAIT) && div_rsp.done) begin
      tops_q[ch_q] <= top_calc;
    end
    if (state_q == ST_OUT) begin
      result_q.red_top    <= tops_q[0];
      result_q.green_top  <= tops_q[1];
      result_q.blue_top   <= tops_q[2];
      result_q.peak_value <= rhbh_pkg::PEAK_OUT_W'(peak_q);
    end
  end

  assign result_valid_o = res_vld_q;
  assign result_o       = result_q;

  // The result strobe lasts a single cycle.
  a_strobe_single : assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o)
    else $error("result strobe held for more than one cycle");

  // The divider is never left running while the block reports idle.
  a_div_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> !div_rsp.busy)
    else $error("divider busy while sequencer idle");

  // A divider completion only arrives while the sequencer waits for it.
  a_div_done : assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> (state_q == ST_WAIT))
    else $error("divider finished outside the wait state");

  // The peak only falls through a clear command.
  a_peak_mono : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !clr_en |=> (peak_q >= $past(peak_q)))
    else $error("peak decreased without a clear");

endmodule

`default_nettype wire

// ----- tb/tb_rgb_histogram_bar_heights.sv -----
// Self-checking testbench for the RGB histogram bar-height engine.
// Needs rhbh_pkg, rhbh_divider and rgb_histogram_bar_heights; a behavioral
// histogram in the bench predicts every query result and a monitor checks each beat.
`timescale 1ns / 100ps

module tb_rgb_histogram_bar_heights;

  // The fourth opcode has no package name; the block must ignore it.
  localparam logic [rhbh_pkg::OPC_W-1:0] OP_UNUSED = 2'd3;
  localparam int unsigned                NUM_CHAN  = 3;

  logic                        clk_i = 1'b0;
  logic                        rst_ni;
  logic                        start;
  logic                        busy;
  rhbh_pkg::cmd_t              cmd_i;
  logic                        result_valid_o;
  rhbh_pkg::result_t           result_o;
  logic                        psel;
  logic                        penable;
  logic                        pwrite;
  logic [rhbh_pkg::APB_AW-1:0] paddr;
  logic [rhbh_pkg::APB_DW-1:0] pwdata;
  logic [rhbh_pkg::APB_DW-1:0] prdata;
  logic                        pready;

  // Bench copy of the histogram and its configuration.
  logic [rhbh_pkg::COUNT_W-1:0] bin_count [NUM_CHAN][rhbh_pkg::NUM_BINS];
  logic [rhbh_pkg::COUNT_W-1:0] peak_count;
  logic [rhbh_pkg::MASK_W-1:0]  cfg_mask;
  logic [rhbh_pkg::DIM_W-1:0]   cfg_width;
  logic [rhbh_pkg::DIM_W-1:0]   cfg_height;

  // Bar tops still owed by the block, oldest first.
  rhbh_pkg::result_t tops_due [$];
  rhbh_pkg::result_t front_due;
  int                mismatch_count = 0;

  rgb_histogram_bar_heights uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .cmd_i          (cmd_i),
    .result_valid_o (result_valid_o),
    .result_o       (result_o),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  always #5 clk_i = ~clk_i;

  // Only the first few mismatches are printed; the rest are counted.
  task automatic check_field(input string what, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      mismatch_count++;
      if (mismatch_count <= 10) begin
        $display("%0t: %s mismatch: expected %0d, got %0d", $time, what, want, got);
      end
    end
  endtask

  // Every result beat is compared with the oldest outstanding query.
  always @(posedge clk_i) begin
    if (rst_ni === 1'b1 && result_valid_o === 1'b1) begin
      if (tops_due.size() == 0) begin
        check_field("unexpected result beat, peak_value", '0, 32'hFFFF_FFFF);
      end else begin
        front_due = tops_due.pop_front();
        check_field("red_top", 32'(front_due.red_top), 32'(result_o.red_top));
        check_field("green_top", 32'(front_due.green_top), 32'(result_o.green_top));
        check_field("blue_top", 32'(front_due.blue_top), 32'(result_o.blue_top));
        check_field("peak_value", front_due.peak_value, result_o.peak_value);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Histogram prediction
  // ---------------------------------------------------------------------------

  task automatic clear_bins();
    for (int ch = 0; ch < NUM_CHAN; ch++) begin
      for (int b = 0; b < rhbh_pkg::NUM_BINS; b++) begin
        bin_count[ch][b] = '0;
      end
    end
    peak_count = '0;
  endtask

  // Saturating count; only bins below the image width feed the peak.
  task automatic bump_bin(input int ch, input logic [rhbh_pkg::SAMPLE_W-1:0] idx);
    if (bin_count[ch][idx] != '1) begin
      bin_count[ch][idx] = bin_count[ch][idx] + rhbh_pkg::COUNT_W'(1);
    end
    if (rhbh_pkg::DIM_W'(idx) < cfg_width && bin_count[ch][idx] > peak_count) begin
      peak_count = bin_count[ch][idx];
    end
  endtask

  // Top row of one bar, rounded to the nearest row with halves going up.
  function automatic logic [rhbh_pkg::DIM_W-1:0] bar_top_row(
      input int ch, input logic [rhbh_pkg::COL_W-1:0] col);
    logic [63:0] rows;
    if (!cfg_mask[ch] || peak_count == '0 || 32'(col) >= rhbh_pkg::NUM_BINS) begin
      return cfg_height;
    end
    rows = (64'(cfg_height) * 64'd2 * 64'(bin_count[ch][col[rhbh_pkg::BIN_W-1:0]])
            + 64'(peak_count)) / (64'(peak_count) * 64'd2);
    if (rows >= 64'(cfg_height)) begin
      return '0;
    end
    return cfg_height - rows[rhbh_pkg::DIM_W-1:0];
  endfunction

  task automatic predict_cmd(input rhbh_pkg::cmd_t c);
    logic [rhbh_pkg::SAMPLE_W-1:0] smp [NUM_CHAN];
    rhbh_pkg::result_t             tops;
    smp[0] = c.red_sample;
    smp[1] = c.green_sample;
    smp[2] = c.blue_sample;
    case (c.opcode)
      rhbh_pkg::OP_CLEAR: begin
        clear_bins();
      end
      rhbh_pkg::OP_ADD: begin
        for (int ch = 0; ch < NUM_CHAN; ch++) begin
          if (cfg_mask[ch]) begin
            bump_bin(ch, smp[ch]);
          end
        end
      end
      rhbh_pkg::OP_QUERY: begin
        tops.red_top    = bar_top_row(0, c.column);
        tops.green_top  = bar_top_row(1, c.column);
        tops.blue_top   = bar_top_row(2, c.column);
        tops.peak_value = peak_count;
        tops_due.push_back(tops);
      end
      default: begin
      end
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Command and configuration drivers
  // ---------------------------------------------------------------------------

  function automatic rhbh_pkg::cmd_t make_cmd(input logic [rhbh_pkg::OPC_W-1:0] opc,
                                              input logic [rhbh_pkg::SAMPLE_W-1:0] r,
                                              input logic [rhbh_pkg::SAMPLE_W-1:0] g,
                                              input logic [rhbh_pkg::SAMPLE_W-1:0] b,
                                              input logic [rhbh_pkg::COL_W-1:0] col);
    rhbh_pkg::cmd_t c;
    c.opcode       = opc;
    c.red_sample   = r;
    c.green_sample = g;
    c.blue_sample  = b;
    c.column       = col;
    return c;
  endfunction

  // Random sample and column values for fields that an opcode ignores.
  function automatic logic [rhbh_pkg::SAMPLE_W-1:0] rand_sample();
    return rhbh_pkg::SAMPLE_W'($urandom);
  endfunction

  function automatic logic [rhbh_pkg::COL_W-1:0] rand_col();
    return rhbh_pkg::COL_W'($urandom);
  endfunction

  // Start stays high after acceptance; the next call or a pause decides.
  task automatic send_cmd(input rhbh_pkg::cmd_t c);
    @(negedge clk_i);
    start <= 1'b1;
    cmd_i <= c;
    do @(posedge clk_i); while (busy !== 1'b0);
    predict_cmd(c);
  endtask

  task automatic idle_sender(input int cycles);
    @(negedge clk_i);
    start <= 1'b0;
    repeat (cycles - 1) @(negedge clk_i);
  endtask

  // Waits until every query has answered and the last command has retired.
  task automatic wait_drain();
    @(negedge clk_i);
    start <= 1'b0;
    while (tops_due.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    while (busy !== 1'b0) @(posedge clk_i);
  endtask

  task automatic check_reg(input rhbh_pkg::reg_idx_e idx,
                           input logic [rhbh_pkg::APB_DW-1:0] want);
    @(negedge clk_i);
    start   <= 1'b0;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    check_field("register readback", want, prdata);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // A write is always followed by a readback of the same register.
  task automatic write_reg(input rhbh_pkg::reg_idx_e idx,
                           input logic [rhbh_pkg::APB_DW-1:0] value);
    @(negedge clk_i);
    start   <= 1'b0;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    case (idx)
      rhbh_pkg::REG_CHANNEL_MASK: cfg_mask   = value[rhbh_pkg::MASK_W-1:0];
      rhbh_pkg::REG_OUT_WIDTH:    cfg_width  = value[rhbh_pkg::DIM_W-1:0];
      rhbh_pkg::REG_OUT_HEIGHT:   cfg_height = value[rhbh_pkg::DIM_W-1:0];
      default: begin
      end
    endcase
    check_reg(idx, value);
  endtask

  task automatic set_config(input int mask, input int width, input int height);
    write_reg(rhbh_pkg::REG_CHANNEL_MASK, mask);
    write_reg(rhbh_pkg::REG_OUT_WIDTH, width);
    write_reg(rhbh_pkg::REG_OUT_HEIGHT, height);
  endtask

  // Mostly near a hot bin so counts pile up, sometimes anywhere.
  function automatic logic [rhbh_pkg::SAMPLE_W-1:0] pick_sample(
      input logic [rhbh_pkg::SAMPLE_W-1:0] hot);
    if ($urandom_range(0, 3) != 0) begin
      return hot + rhbh_pkg::SAMPLE_W'($urandom_range(0, 7));
    end
    return rhbh_pkg::SAMPLE_W'($urandom_range(0, 255));
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  task automatic test_reset_registers();
    check_reg(rhbh_pkg::REG_CHANNEL_MASK, rhbh_pkg::APB_DW'(rhbh_pkg::MASK_RST));
    check_reg(rhbh_pkg::REG_OUT_WIDTH, rhbh_pkg::APB_DW'(rhbh_pkg::WIDTH_RST));
    check_reg(rhbh_pkg::REG_OUT_HEIGHT, rhbh_pkg::APB_DW'(rhbh_pkg::HEIGHT_RST));
  endtask

  // Field extremes at the reset configuration.
  task automatic test_field_extremes();
    send_cmd(make_cmd(rhbh_pkg::OP_QUERY, 8'd0, 8'd0, 8'd0, 12'd0));      // empty histogram
    send_cmd(make_cmd(OP_UNUSED, 8'hFF, 8'hFF, 8'hFF, 12'hFFF));          // ignored
    send_cmd(make_cmd(rhbh_pkg::OP_ADD, 8'd0, 8'd0, 8'd0, 12'd0));
    send_cmd(make_cmd(rhbh_pkg::OP_ADD, 8'hFF, 8'hFF, 8'hFF, 12'hFFF));
    send_cmd(make_cmd(rhbh_pkg::OP_ADD, 8'hFF, 8'd128, 8'd0, 12'd0));
    send_cmd(make_cmd(rhbh_pkg::OP_ADD, 8'hAA, 8'h55, 8'hAA, 12'hAAA));
    send_cmd(make_cmd(rhbh_pkg::OP_ADD, 8'h55, 8'hAA, 8'h55, 12'h555));
    send_cmd(make_cmd(rhbh_pkg::OP_QUERY, 8'd0, 8'd0, 8'd0, 12'd0));
    send_cmd(make_cmd(rhbh_pkg::OP_QUERY, 8'd0, 8'd0, 8'd0, 12'd255));
    send_cmd(make_cmd(rhbh_pkg::OP_QUERY, 8'd0, 8'd0, 8'd0, 12'hAA));
    send_cmd(make_cmd(rhbh_pkg::OP_QUERY, 8'd0, 8'd0, 8'd0, 12'd256));    // past the last bin
    send_cmd(make_cmd(rhbh_pkg::OP_QUERY, 8'hFF, 8'hFF, 8'hFF, 12'hFFF));
    send_cmd(make_cmd(rhbh_pkg::OP_CLEAR, 8'hFF, 8'hFF, 8'hFF, 12'hFFF));
    send_cmd(make_cmd(rhbh_pkg::OP_QUERY, 8'd0, 8'd0, 8'd0, 12'd255));
    send_cmd(make_cmd(rhbh_pkg::OP_ADD, 8'd1, 8'd2, 8'd3, 12'd0));
    send_cmd(make_cmd(rhbh_pkg::OP_QUERY, 8'd0, 8'd0, 8'd0, 12'd1));
  endtask

  // Narrow and zero width, zero height, all channels off.
  task automatic test_special_settings();
    wait_drain();
    write_reg(rhbh_pkg::REG_OUT_WIDTH, 1);
    // Bin 200 lies past the width, so its count climbs above the peak.
    send_cmd(make_cmd(rhbh_pkg::OP_ADD, 8'd200, 8'd200, 8'd200, 12'd0));
    send_cmd(make_cmd(rhbh_pkg::OP_ADD, 8'd200, 8'd200, 8'd200, 12'd0));
    send_cmd(make_cmd(rhbh_pkg::OP_QUERY, 8'd0, 8'd0, 8'd0, 12'd200));
    send_cmd(make_cmd(rhbh_pkg::OP_QUERY, 8'd0, 8'd0, 8'd0, 12'd1));
    wait_drain();
    write_reg(rhbh_pkg::REG_OUT_WIDTH, 0);
    send_cmd(make_cmd(rhbh_pkg::OP_CLEAR, 8'd0, 8'd0, 8'd0, 12'd0));
    send_cmd(make_cmd(rhbh_pkg::OP_ADD, 8'd5, 8'd5, 8'd5, 12'd0));
    send_cmd(make_cmd(rhbh_pkg::OP_QUERY, 8'd0, 8'd0, 8'd0, 12'd5));
    wait_drain();
    write_reg(rhbh_pkg::REG_OUT_WIDTH, 256);
    write_reg(rhbh_pkg::REG_OUT_HEIGHT, 0);
    send_cmd(make_cmd(rhbh_pkg::OP_ADD, 8'd5, 8'd5, 8'd5, 12'd0));
    send_cmd(make_cmd(rhbh_pkg::OP_QUERY, 8'd0, 8'd0, 8'd0, 12'd5));
    wait_drain();
    write_reg(rhbh_pkg::REG_OUT_HEIGHT, 4096);
    write_reg(rhbh_pkg::REG_CHANNEL_MASK, 0);
    send_cmd(make_cmd(rhbh_pkg::OP_ADD, 8'd9, 8'd9, 8'd9, 12'd0));
    send_cmd(make_cmd(rhbh_pkg::OP_QUERY, 8'd0, 8'd0, 8'd0, 12'd5));
  endtask

  // One phase: a fresh setting, then mostly adds around hot bins with queries.
  task automatic run_random_phase(input int phase, input int n_items);
    int                            widths [4]  = '{4096, 1, 0, 256};
    int                            heights [4] = '{1, 4096, 200, 0};
    int                            masks [4]   = '{7, 5, 3, 6};
    int                            mask, width, height, roll, hot_top;
    bit                            calm;
    logic [rhbh_pkg::SAMPLE_W-1:0] hot [NUM_CHAN];
    logic [rhbh_pkg::COL_W-1:0]    col;
    wait_drain();
    if (phase < 4) begin
      mask   = masks[phase];
      width  = widths[phase];
      height = heights[phase];
    end else begin
      mask   = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 7) : 7;
      width  = $urandom_range(0, 1) ? $urandom_range(1, 4096) : $urandom_range(1, 300);
      height = $urandom_range(1, 4096);
    end
    set_config(mask, width, height);
    // Keep the hot bins mostly inside the image so the peak moves.
    hot_top = (width == 0) ? 0 : ((width > 256) ? 255 : width - 1);
    for (int ch = 0; ch < NUM_CHAN; ch++) begin
      hot[ch] = rhbh_pkg::SAMPLE_W'($urandom_range(0, hot_top));
    end
    // Without a clear, counts from earlier settings can exceed the new peak.
    if (phase == 0 || $urandom_range(0, 1) == 1) begin
      send_cmd(make_cmd(rhbh_pkg::OP_CLEAR, rand_sample(), rand_sample(), rand_sample(),
                        rand_col()));
    end
    calm = ($urandom_range(0, 3) == 0);
    for (int i = 0; i < n_items; i++) begin
      if (phase == 3 && i == n_items / 2) begin
        wait_drain();
      end
      roll = $urandom_range(0, 99);
      if (roll < 2) begin
        send_cmd(make_cmd(rhbh_pkg::OP_CLEAR, rand_sample(), rand_sample(), rand_sample(),
                          rand_col()));
      end else if (roll < 4) begin
        send_cmd(make_cmd(OP_UNUSED, rand_sample(), rand_sample(), rand_sample(),
                          rand_col()));
      end else if (roll < 16) begin
        roll = $urandom_range(0, 99);
        if (roll < 50) begin
          col = rhbh_pkg::COL_W'(hot[$urandom_range(0, 2)] +
                                 rhbh_pkg::SAMPLE_W'($urandom_range(0, 7)));
        end else if (roll < 70) begin
          col = rhbh_pkg::COL_W'(width + $urandom_range(0, 2) - 1);
        end else begin
          col = rhbh_pkg::COL_W'($urandom_range(0, 4095));
        end
        send_cmd(make_cmd(rhbh_pkg::OP_QUERY, rand_sample(), rand_sample(), rand_sample(),
                          col));
      end else begin
        send_cmd(make_cmd(rhbh_pkg::OP_ADD, pick_sample(hot[0]), pick_sample(hot[1]),
                          pick_sample(hot[2]), rand_col()));
      end
      if (!calm && $urandom_range(0, 5) == 0) begin
        idle_sender($urandom_range(1, 19));
      end
    end
  endtask

  task automatic test_random_phases();
    for (int phase = 0; phase < 14; phase++) begin
      run_random_phase(phase, 100);
    end
  endtask

  // Back-to-back beats at the default setting, no pauses at all.
  task automatic test_streaming(input int n_items);
    logic [rhbh_pkg::SAMPLE_W-1:0] hot;
    wait_drain();
    set_config(rhbh_pkg::MASK_RST, rhbh_pkg::WIDTH_RST, rhbh_pkg::HEIGHT_RST);
    hot = rhbh_pkg::SAMPLE_W'($urandom_range(0, 255));
    for (int i = 0; i < n_items; i++) begin
      if ($urandom_range(0, 4) == 0) begin
        send_cmd(make_cmd(rhbh_pkg::OP_QUERY, rand_sample(), rand_sample(), rand_sample(),
                          rhbh_pkg::COL_W'(hot + rhbh_pkg::SAMPLE_W'($urandom_range(0, 7)))));
      end else begin
        send_cmd(make_cmd(rhbh_pkg::OP_ADD, pick_sample(hot), pick_sample(hot),
                          pick_sample(hot), rand_col()));
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Run sequence
  // ---------------------------------------------------------------------------

  initial begin
    rst_ni  = 1'b0;
    start   = 1'b0;
    cmd_i   = '0;
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = '0;
    pwdata  = '0;
    cfg_mask   = rhbh_pkg::MASK_RST;
    cfg_width  = rhbh_pkg::WIDTH_RST;
    cfg_height = rhbh_pkg::HEIGHT_RST;
    clear_bins();
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_reset_registers();
    test_field_extremes();
    test_special_settings();
    test_random_phases();
    test_streaming(125);

    wait_drain();
    repeat (200) @(posedge clk_i);
    if (mismatch_count == 0 && tops_due.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Hang guard, several times the slowest legal run.
  initial begin
    #50ms;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
